[hdl/esc_pkg.sv]
// Shared types, constants and register codes for the environmental sensor
// compensation block. No dependencies; every other file in hdl/ imports it.
package esc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed-point constants of the compensation formulas
  localparam logic signed [63:0] P_TFINE_OFS = 64'sd128000;
  localparam logic signed [63:0] H_TFINE_OFS = 64'sd76800;
  localparam logic signed [63:0] P_BASE      = 64'sd1048576;
  localparam logic signed [63:0] P_SCALE     = 64'sd3125;
  localparam logic signed [63:0] P_BIAS      = 64'sd140737488355328; // 2^47
  localparam logic signed [63:0] H_MAX       = 64'sd419430400;
  localparam logic signed [63:0] H_ROUND     = 64'sd16384;
  localparam logic signed [63:0] H_Y_OFS     = 64'sd2097152;
  localparam logic signed [63:0] H_Y_ROUND   = 64'sd8192;
  localparam logic signed [63:0] H_Z_OFS     = 64'sd32768;
  localparam logic signed [63:0] P_SAT       = 64'sh0000_0000_FFFF_FFFF;

  typedef enum logic [2:0] {
    REG_CAL_T, REG_CAL_PA, REG_CAL_PB, REG_CAL_MIX,
    REG_CAL_H, REG_T_HIGH, REG_T_LOW, REG_H_HIGH
  } esc_reg_t;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] adc_humidity;
  } esc_in_t;

  typedef struct packed {
    logic signed [19:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
    logic               temp_alarm;
    logic               hum_alarm;
  } esc_out_t;

  typedef struct packed {
    logic [47:0]        cal_t;
    logic [63:0]        cal_pa;
    logic [63:0]        cal_pb;
    logic [47:0]        cal_mix;
    logic [31:0]        cal_h;
    logic signed [19:0] t_high;
    logic signed [19:0] t_low;
    logic [16:0]        h_high;
  } esc_cfg_t;

  // Word passed from the front end to the back end through the queue
  typedef struct packed {
    logic signed [25:0] tfine;
    logic signed [19:0] temp;
    logic               temp_alert;
    logic [19:0]        raw_pressure;
    logic [15:0]        adc_humidity;
  } esc_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AA, ST_B6, ST_B5, ST_A3, ST_A2, ST_A1, ST_NUM,
    ST_DSET, ST_DRUN, ST_DFIN, ST_C1, ST_C2, ST_E, ST_PFIN,
    ST_H5, ST_H6, ST_H3, ST_YZ, ST_H2, ST_XY, ST_XX, ST_H1, ST_HFIN
  } esc_state_t;

endpackage

[hdl/esc_front.sv]
// Front end: accepts bursts, computes the fine temperature term, temperature
// and its alert in a three-stage pipeline, and pushes words into the queue.
// Depends on esc_pkg.
module esc_front #(
  parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH_DEF,
  parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  esc_pkg::esc_in_t   burst,
  input  esc_pkg::esc_cfg_t  cfg,
  input  logic [LVL_W-1:0]   level,
  output logic               busy,
  output logic               push,
  output esc_pkg::esc_item_t push_item
);
  import esc_pkg::*;

  logic s1v, s2v, s3v;
  logic signed [19:0] x1;
  logic signed [17:0] d1;
  logic signed [35:0] m1, dd;
  logic signed [24:0] a3;
  logic signed [39:0] m2;
  logic [19:0] ap1, ap2, ap3;
  logic [15:0] ah1, ah2, ah3;
  logic signed [15:0] t2s, t3s;
  logic [15:0] t1;
  logic [LVL_W:0] occ;
  logic signed [25:0] tf;
  logic signed [29:0] t5;
  logic signed [21:0] temp_full;
  logic take;

  assign t1  = cfg.cal_t[15:0];
  assign t2s = $signed(cfg.cal_t[31:16]);
  assign t3s = $signed(cfg.cal_t[47:32]);

  // Count words in flight so the queue can never overflow
  assign occ  = (LVL_W+1)'(level) + (LVL_W+1)'(s1v) + (LVL_W+1)'(s2v) + (LVL_W+1)'(s3v);
  assign busy = occ >= (LVL_W+1)'(QUEUE_DEPTH);
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
    end else begin
      s1v <= take;
      s2v <= s1v;
      s3v <= s2v;
    end
    x1  <= $signed({3'b0, burst.adc_temperature[19:3]}) - $signed({3'b0, t1, 1'b0});
    d1  <= $signed({2'b0, burst.adc_temperature[19:4]}) - $signed({2'b0, t1});
    ap1 <= burst.raw_pressure;
    ah1 <= burst.adc_humidity;
    m1  <= 36'(x1) * 36'(t2s);
    dd  <= 36'(d1) * 36'(d1);
    ap2 <= ap1;
    ah2 <= ah1;
    a3  <= 25'(m1 >>> 11);
    m2  <= 40'($signed(dd[35:12])) * 40'(t3s);
    ap3 <= ap2;
    ah3 <= ah2;
  end

  assign tf        = 26'(a3) + 26'(m2 >>> 14);
  assign t5        = 30'(tf) * 30'sd5 + 30'sd128;
  assign temp_full = 22'(t5 >>> 8);

  always_comb begin
    push                    = s3v;
    push_item.tfine         = tf;
    push_item.temp          = temp_full[19:0];
    push_item.temp_alert    = (temp_full > 22'(cfg.t_high)) || (temp_full < 22'(cfg.t_low));
    push_item.raw_pressure  = ap3;
    push_item.adc_humidity  = ah3;
  end

endmodule

[hdl/esc_queue.sv]
// Short queue between the front end and the back end.
// Depends on esc_pkg.
module esc_queue #(
  parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH_DEF,
  parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  esc_pkg::esc_item_t push_item,
  input  logic               pop,
  output esc_pkg::esc_item_t head,
  output logic               nonempty,
  output logic [LVL_W-1:0]   level
);
  import esc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  esc_item_t       mem [QUEUE_DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [LVL_W-1:0] cnt;

  assign head     = mem[rp];
  assign nonempty = cnt != '0;
  assign level    = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
    if (push) mem[wp] <= push_item;
  end

endmodule

[hdl/esc_back.sv]
// Back end: pressure and humidity compensation on a shared 32x32 multiplier
// (one 64-bit product at a time, from partial products) and a bit-serial divider. Depends on esc_pkg.
module esc_back (
  input  logic               clk,
  input  logic               rst,
  input  esc_pkg::esc_cfg_t  cfg,
  input  logic               q_valid,
  input  esc_pkg::esc_item_t q_item,
  output logic               q_pop,
  output logic               done,
  output esc_pkg::esc_out_t  result
);
  import esc_pkg::*;

  esc_state_t state, state_next;
  logic [1:0] phase;
  logic       is_mul, mdone;
  logic [63:0] mop_a, mop_b, acc, prod;
  logic [31:0] mx, my;
  logic signed [63:0] acc_s;

  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  logic signed [63:0] pa, pb, w0, w1, num, pp, hx, hy, hz, ha, hu;
  logic signed [31:0] den;
  logic [63:0] nq;
  logic [32:0] rem, rem_sh;
  logic [31:0] dmag;
  logic        qneg;
  logic [5:0]  cnt;
  logic [19:0] apr;
  logic [15:0] ahr;
  logic signed [19:0] tempr;
  logic        talr;
  logic [31:0] pres;
  logic        pval;
  logic signed [63:0] pn, psum, huc, den_full;

  assign p1 = $signed({48'b0, cfg.cal_pa[15:0]});
  assign p2 = 64'($signed(cfg.cal_pa[31:16]));
  assign p3 = 64'($signed(cfg.cal_pa[47:32]));
  assign p4 = 64'($signed(cfg.cal_pa[63:48]));
  assign p5 = 64'($signed(cfg.cal_pb[15:0]));
  assign p6 = 64'($signed(cfg.cal_pb[31:16]));
  assign p7 = 64'($signed(cfg.cal_pb[47:32]));
  assign p8 = 64'($signed(cfg.cal_pb[63:48]));
  assign p9 = 64'($signed(cfg.cal_mix[15:0]));
  assign h1 = $signed({56'b0, cfg.cal_mix[23:16]});
  assign h2 = 64'($signed(cfg.cal_mix[39:24]));
  assign h3 = $signed({56'b0, cfg.cal_mix[47:40]});
  assign h4 = 64'($signed(cfg.cal_h[11:0]));
  assign h5 = 64'($signed(cfg.cal_h[23:12]));
  assign h6 = 64'($signed(cfg.cal_h[31:24]));

  assign acc_s    = $signed(acc);
  assign mdone    = phase == 2'd3;
  assign pn       = P_BASE - $signed({44'b0, apr});
  assign den_full = acc_s >>> 33;
  assign rem_sh   = {rem[31:0], nq[63]};
  assign psum     = ((pp + w0 + w1) >>> 8) + (p7 <<< 4);
  assign huc      = (hu < 0) ? 64'sd0 : ((hu > H_MAX) ? H_MAX : hu);

  // Partial products: low x low, low x high, high x low
  assign mx   = (phase == 2'd2) ? mop_a[63:32] : mop_a[31:0];
  assign my   = (phase == 2'd1) ? mop_b[63:32] : mop_b[31:0];
  assign prod = 64'(mx) * 64'(my);

  // Outputs of the sequencer: multiplier operands and queue pop
  always_comb begin
    is_mul = 1'b1;
    mop_a  = '0;
    mop_b  = '0;
    q_pop  = 1'b0;
    unique case (state)
      ST_AA:  begin mop_a = pa;                 mop_b = pa;        end
      ST_B6:  begin mop_a = w0;                 mop_b = p6;        end
      ST_B5:  begin mop_a = pa;                 mop_b = p5;        end
      ST_A3:  begin mop_a = w0;                 mop_b = p3;        end
      ST_A2:  begin mop_a = pa;                 mop_b = p2;        end
      ST_A1:  begin mop_a = w1;                 mop_b = p1;        end
      ST_NUM: begin mop_a = (pn <<< 31) - pb;   mop_b = P_SCALE;   end
      ST_C1:  begin mop_a = p9;                 mop_b = pp >>> 13; end
      ST_C2:  begin mop_a = w0;                 mop_b = pp >>> 13; end
      ST_E:   begin mop_a = p8;                 mop_b = pp;        end
      ST_H5:  begin mop_a = h5;                 mop_b = ha;        end
      ST_H6:  begin mop_a = ha;                 mop_b = h6;        end
      ST_H3:  begin mop_a = ha;                 mop_b = h3;        end
      ST_YZ:  begin mop_a = hy;                 mop_b = hz;        end
      ST_H2:  begin mop_a = hy;                 mop_b = h2;        end
      ST_XY:  begin mop_a = hx;                 mop_b = hy;        end
      ST_XX:  begin mop_a = hu >>> 15;          mop_b = hu >>> 15; end
      ST_H1:  begin mop_a = w0;                 mop_b = h1;        end
      ST_IDLE: begin is_mul = 1'b0; q_pop = q_valid; end
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_AA;
      ST_AA:   if (mdone) state_next = ST_B6;
      ST_B6:   if (mdone) state_next = ST_B5;
      ST_B5:   if (mdone) state_next = ST_A3;
      ST_A3:   if (mdone) state_next = ST_A2;
      ST_A2:   if (mdone) state_next = ST_A1;
      ST_A1:   if (mdone) state_next = (den_full == 0) ? ST_H5 : ST_NUM;
      ST_NUM:  if (mdone) state_next = ST_DSET;
      ST_DSET: state_next = ST_DRUN;
      ST_DRUN: if (cnt == 6'd63) state_next = ST_DFIN;
      ST_DFIN: state_next = ST_C1;
      ST_C1:   if (mdone) state_next = ST_C2;
      ST_C2:   if (mdone) state_next = ST_E;
      ST_E:    if (mdone) state_next = ST_PFIN;
      ST_PFIN: state_next = ST_H5;
      ST_H5:   if (mdone) state_next = ST_H6;
      ST_H6:   if (mdone) state_next = ST_H3;
      ST_H3:   if (mdone) state_next = ST_YZ;
      ST_YZ:   if (mdone) state_next = ST_H2;
      ST_H2:   if (mdone) state_next = ST_XY;
      ST_XY:   if (mdone) state_next = ST_XX;
      ST_XX:   if (mdone) state_next = ST_H1;
      ST_H1:   if (mdone) state_next = ST_HFIN;
      ST_HFIN: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= is_mul ? phase + 2'd1 : 2'd0;
      done  <= state == ST_HFIN;
    end

    if (is_mul) begin
      unique case (phase)
        2'd0:        acc <= prod;
        2'd1, 2'd2:  acc[63:32] <= acc[63:32] + prod[31:0];
        2'd3:        acc <= acc;
      endcase
    end

    if (state == ST_IDLE && q_valid) begin
      pa    <= 64'(q_item.tfine) - P_TFINE_OFS;
      ha    <= 64'(q_item.tfine) - H_TFINE_OFS;
      apr   <= q_item.raw_pressure;
      ahr   <= q_item.adc_humidity;
      tempr <= q_item.temp;
      talr  <= q_item.temp_alert;
    end

    if (is_mul && mdone) begin
      unique case (state)
        ST_AA:  w0  <= acc_s;
        ST_B6:  pb  <= acc_s;
        ST_B5:  pb  <= pb + (acc_s <<< 17) + (p4 <<< 35);
        ST_A3:  w1  <= acc_s >>> 8;
        ST_A2:  w1  <= w1 + (acc_s <<< 12) + P_BIAS;
        ST_A1:  begin
          den  <= 32'(den_full);
          pval <= 1'b0;
          pres <= '0;
        end
        ST_NUM: num <= acc_s;
        ST_C1:  w0  <= acc_s;
        ST_C2:  w0  <= acc_s >>> 25;
        ST_E:   w1  <= acc_s >>> 19;
        ST_H5:  hx  <= (($signed({34'b0, ahr, 14'b0}) - (h4 <<< 20) - acc_s) + H_ROUND) >>> 15;
        ST_H6:  hy  <= acc_s >>> 10;
        ST_H3:  hz  <= (acc_s >>> 11) + H_Z_OFS;
        ST_YZ:  hy  <= (acc_s >>> 10) + H_Y_OFS;
        ST_H2:  hy  <= (acc_s + H_Y_ROUND) >>> 14;
        ST_XY:  hu  <= acc_s;
        ST_XX:  w0  <= acc_s >>> 7;
        ST_H1:  hu  <= hu - (acc_s >>> 4);
        default: ;
      endcase
    end

    // Divide magnitudes one quotient bit per cycle, then fix the sign
    unique case (state)
      ST_DSET: begin
        nq   <= num[63] ? 64'(-num) : 64'(num);
        dmag <= den[31] ? 32'(-den) : 32'(den);
        qneg <= num[63] ^ den[31];
        rem  <= '0;
        cnt  <= '0;
      end
      ST_DRUN: begin
        cnt <= cnt + 6'd1;
        if (rem_sh >= {1'b0, dmag}) begin
          rem <= rem_sh - {1'b0, dmag};
          nq  <= {nq[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          nq  <= {nq[62:0], 1'b0};
        end
      end
      ST_DFIN: pp <= qneg ? -$signed(nq) : $signed(nq);
      ST_PFIN: begin
        pval <= 1'b1;
        pres <= (psum < 0) ? 32'd0 : ((psum > P_SAT) ? 32'hFFFF_FFFF : psum[31:0]);
      end
      ST_HFIN: begin
        result.temperature_centi <= tempr;
        result.pressure_q24_8    <= pres;
        result.pressure_valid    <= pval;
        result.humidity_q22_10   <= huc[28:12];
        result.temp_alarm        <= talr;
        result.hum_alarm         <= huc[28:12] > cfg.h_high;
      end
      default: ;
    endcase
  end

endmodule

[hdl/env_sensor_compensation.sv]
// Top level of the environmental sensor compensation block: register file,
// APB-style port, front end, queue and back end. Depends on esc_pkg.
//
// Usage:
//  - Program calibration words and alert limits over the APB-style port
//    (64-bit data, register i at byte address 8*i) while the block is idle.
//  - Drive a burst on burst and raise start; the word is taken at an edge
//    where start is high and busy is low.
//  - Each result appears on result for exactly one cycle with done high.
//    The receiver cannot stall; results are never held.
// Flow:
//  - The front end takes one burst per cycle while busy is low and runs
//    a three-stage temperature pipeline; busy rises once the queue and
//    the pipeline hold QUEUE_DEPTH words.
//  - The back end builds each 64-bit product on one 32x32 multiplier and
//    divides in a bit-serial pressure divider, which it skips when the
//    pressure divisor is zero. It takes the next word from the queue only
//    once it is idle again.
// Reset: rst (synchronous) clears the pipeline, queue and sequencer and
// loads the calibration and limit registers with their defaults.
module env_sensor_compensation #(
  parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  esc_pkg::esc_in_t  burst,
  output logic              done,
  output esc_pkg::esc_out_t result
);
  import esc_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  esc_cfg_t  cfg;
  esc_reg_t  idx;
  esc_item_t push_item, head;
  logic      push, pop, nonempty;
  logic [LVL_W-1:0] level;

  assign pready = 1'b1;
  assign idx    = esc_reg_t'(paddr[5:3]);

  // Register writes keep only each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_t   <= '0;
      cfg.cal_pa  <= '0;
      cfg.cal_pb  <= '0;
      cfg.cal_mix <= '0;
      cfg.cal_h   <= '0;
      cfg.t_high  <= 20'sd8500;
      cfg.t_low   <= -20'sd4000;
      cfg.h_high  <= 17'd102400;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_CAL_T:   cfg.cal_t   <= pwdata[47:0];
        REG_CAL_PA:  cfg.cal_pa  <= pwdata;
        REG_CAL_PB:  cfg.cal_pb  <= pwdata;
        REG_CAL_MIX: cfg.cal_mix <= pwdata[47:0];
        REG_CAL_H:   cfg.cal_h   <= pwdata[31:0];
        REG_T_HIGH:  cfg.t_high  <= $signed(pwdata[19:0]);
        REG_T_LOW:   cfg.t_low   <= $signed(pwdata[19:0]);
        REG_H_HIGH:  cfg.h_high  <= pwdata[16:0];
      endcase
    end
  end

  // Read back the raw register contents, zero-extended
  always_comb begin
    unique case (idx)
      REG_CAL_T:   prdata = {16'b0, cfg.cal_t};
      REG_CAL_PA:  prdata = cfg.cal_pa;
      REG_CAL_PB:  prdata = cfg.cal_pb;
      REG_CAL_MIX: prdata = {16'b0, cfg.cal_mix};
      REG_CAL_H:   prdata = {32'b0, cfg.cal_h};
      REG_T_HIGH:  prdata = {44'b0, cfg.t_high};
      REG_T_LOW:   prdata = {44'b0, cfg.t_low};
      REG_H_HIGH:  prdata = {47'b0, cfg.h_high};
    endcase
  end

  // Front end: take bursts and produce the fine temperature word
  esc_front #(.QUEUE_DEPTH(QUEUE_DEPTH), .LVL_W(LVL_W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .burst     (burst),
    .cfg       (cfg),
    .level     (level),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: decouple the one-per-cycle front from the slow back end
  esc_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .LVL_W(LVL_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty),
    .level     (level)
  );

  // Back end: pressure and humidity, then register the result and pulse done for one cycle
  esc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (nonempty),
    .q_item  (head),
    .q_pop   (pop),
    .done    (done),
    .result  (result)
  );

endmodule

[verif/env_sensor_compensation_tb.sv]
// Self-checking testbench for env_sensor_compensation: drives sensor bursts,
// programs calibration over the APB-style port and checks every result word.
// Depends on esc_pkg and the env_sensor_compensation RTL.
`timescale 1ns / 1ps

module env_sensor_compensation_tb;
  import esc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  esc_in_t     burst = '0;
  logic        done;
  esc_out_t    result;

  env_sensor_compensation dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .burst(burst), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file, updated as each write completes
  logic [47:0]        cal_t;
  logic [63:0]        cal_pa;
  logic [63:0]        cal_pb;
  logic [47:0]        cal_mix;
  logic [31:0]        cal_h;
  logic signed [19:0] t_high;
  logic signed [19:0] t_low;
  logic [16:0]        h_high;

  esc_in_t  burst_backlog[$];
  esc_out_t compensated_words[$];
  int       fails = 0;
  int       cycles = 0;
  int       run_left = 0;
  int       gap_left = 0;

  // Bit-exact compensation: all intermediates are 64-bit two's complement,
  // so plain longint arithmetic gives the wrapping behavior for free.
  function automatic esc_out_t compensate(esc_in_t b);
    longint at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6, a, q, d, tf, tc, p, c, e, x, y, z, hm;
    esc_out_t r;
    at = longint'(b.adc_temperature);
    ap = longint'(b.raw_pressure);
    ah = longint'(b.adc_humidity);
    t1 = longint'(cal_t[15:0]);
    t2 = longint'($signed(cal_t[31:16]));
    t3 = longint'($signed(cal_t[47:32]));
    p1 = longint'(cal_pa[15:0]);
    p2 = longint'($signed(cal_pa[31:16]));
    p3 = longint'($signed(cal_pa[47:32]));
    p4 = longint'($signed(cal_pa[63:48]));
    p5 = longint'($signed(cal_pb[15:0]));
    p6 = longint'($signed(cal_pb[31:16]));
    p7 = longint'($signed(cal_pb[47:32]));
    p8 = longint'($signed(cal_pb[63:48]));
    p9 = longint'($signed(cal_mix[15:0]));
    h1 = longint'(cal_mix[23:16]);
    h2 = longint'($signed(cal_mix[39:24]));
    h3 = longint'(cal_mix[47:40]);
    h4 = longint'($signed(cal_h[11:0]));
    h5 = longint'($signed(cal_h[23:12]));
    h6 = longint'($signed(cal_h[31:24]));

    // fine temperature term
    a = (((at >>> 3) - t1 * 2) * t2) >>> 11;
    d = (at >>> 4) - t1;
    q = (((d * d) >>> 12) * t3) >>> 14;
    tf = a + q;
    tc = (tf * 5 + 128) >>> 8;

    // pressure; a zero divisor flags the word invalid
    a = tf - 128000;
    q = a * a * p6;
    q = q + ((a * p5) <<< 17);
    q = q + (p4 <<< 35);
    a = (((a * a * p3) >>> 8) + ((a * p2) <<< 12));
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    r.pressure_valid = (a != 0);
    if (a == 0) begin
      p = 0;
    end else begin
      p = 1048576 - ap;
      p = ((p <<< 31) - q) * 3125;
      p = (a == -1) ? -p : p / a;
      c = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
      e = (p8 * p) >>> 19;
      p = ((p + c + e) >>> 8) + (p7 <<< 4);
      if (p < 0) p = 0;
      if (p > 64'sh0000_0000_FFFF_FFFF) p = 64'sh0000_0000_FFFF_FFFF;
    end

    // humidity, clamped to 0..100 %
    a = tf - 76800;
    x = ((((ah <<< 14) - (h4 <<< 20)) - h5 * a) + 16384) >>> 15;
    y = (a * h6) >>> 10;
    z = ((a * h3) >>> 11) + 32768;
    y = ((y * z) >>> 10) + 2097152;
    y = (y * h2 + 8192) >>> 14;
    a = x * y;
    x = a >>> 15;
    a = a - ((((x * x) >>> 7) * h1) >>> 4);
    if (a < 0) a = 0;
    if (a > 419430400) a = 419430400;
    hm = a >>> 12;

    r.temperature_centi = tc[19:0];
    r.pressure_q24_8 = p[31:0];
    r.humidity_q22_10 = hm[16:0];
    r.temp_alarm = (tc > longint'(t_high)) || (tc < longint'(t_low));
    r.hum_alarm = (hm > longint'(h_high));
    return r;
  endfunction

  // Register write with setup and access phases; the shadow keeps only the register's width.
  task automatic reg_write(esc_reg_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CAL_T:   cal_t = value[47:0];
      REG_CAL_PA:  cal_pa = value;
      REG_CAL_PB:  cal_pb = value;
      REG_CAL_MIX: cal_mix = value[47:0];
      REG_CAL_H:   cal_h = value[31:0];
      REG_T_HIGH:  t_high = value[19:0];
      REG_T_LOW:   t_low = value[19:0];
      default:     h_high = value[16:0];
    endcase
  endtask

  // Program all eight registers: typical, perturbed, random or all-ones calibration
  task automatic program_set(int mode, logic [19:0] hi, logic [19:0] lo, logic [16:0] hh);
    logic [15:0] w[18];
    w = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
          16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000,
          16'd75, 16'd362, 16'd0, 16'd313, 16'd50, 16'd30};
    for (int i = 0; i < 18; i++) begin
      if (mode == 1) w[i] = w[i] + 16'($urandom_range(0, 64)) - 16'd32;
      if (mode == 2) w[i] = 16'($urandom);
      if (mode == 3) w[i] = 16'hFFFF;
    end
    reg_write(REG_CAL_T, {16'h0, w[2], w[1], w[0]});
    reg_write(REG_CAL_PA, {w[6], w[5], w[4], w[3]});
    reg_write(REG_CAL_PB, {w[10], w[9], w[8], w[7]});
    reg_write(REG_CAL_MIX, {16'h0, w[14][7:0], w[13], w[12][7:0], w[11]});
    reg_write(REG_CAL_H, {32'h0, w[17][7:0], w[16][11:0], w[15][11:0]});
    reg_write(REG_T_HIGH, 64'(hi));
    reg_write(REG_T_LOW, 64'(lo));
    reg_write(REG_H_HIGH, 64'(hh));
  endtask

  // Hold until every queued word is taken and every expected result is back
  task automatic drain();
    do @(negedge clk);
    while (burst_backlog.size() != 0 || start || compensated_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic esc_in_t random_burst();
    esc_in_t b;
    b.adc_temperature = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(400000, 600000));
    b.raw_pressure = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(250000, 450000));
    b.adc_humidity = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(20000, 40000));
    return b;
  endfunction

  // Driver: take a word when start meets !busy, then issue the next one
  // from the backlog in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) compensated_words.push_back(compensate(burst));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (burst_backlog.size() != 0) begin
          start <= 1'b1;
          burst <= burst_backlog.pop_front();
          if (run_left <= 1) begin
            run_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
          end else begin
            run_left <= run_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done word must match the oldest prediction
  always @(posedge clk) begin
    esc_out_t want;
    if (!rst && done) begin
      if (compensated_words.size() == 0) begin
        $error("result word with no prediction waiting");
        fails++;
      end else begin
        want = compensated_words.pop_front();
        if (result.temperature_centi !== want.temperature_centi) begin
          $error("temperature_centi: expected %0d, got %0d",
                 want.temperature_centi, result.temperature_centi);
          fails++;
        end
        if (result.pressure_q24_8 !== want.pressure_q24_8) begin
          $error("pressure_q24_8: expected %0d, got %0d",
                 want.pressure_q24_8, result.pressure_q24_8);
          fails++;
        end
        if (result.pressure_valid !== want.pressure_valid) begin
          $error("pressure_valid: expected %0b, got %0b",
                 want.pressure_valid, result.pressure_valid);
          fails++;
        end
        if (result.humidity_q22_10 !== want.humidity_q22_10) begin
          $error("humidity_q22_10: expected %0d, got %0d",
                 want.humidity_q22_10, result.humidity_q22_10);
          fails++;
        end
        if (result.temp_alarm !== want.temp_alarm) begin
          $error("temp_alarm: expected %0b, got %0b",
                 want.temp_alarm, result.temp_alarm);
          fails++;
        end
        if (result.hum_alarm !== want.hum_alarm) begin
          $error("hum_alarm: expected %0b, got %0b",
                 want.hum_alarm, result.hum_alarm);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    esc_in_t b;
    // reset values of the register file
    cal_t = '0;
    cal_pa = '0;
    cal_pb = '0;
    cal_mix = '0;
    cal_h = '0;
    t_high = 20'sd8500;
    t_low = -20'sd4000;
    h_high = 17'd102400;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Defaults: all calibration zero, so the pressure divisor is zero
    b = '0;
    burst_backlog.push_back(b);
    b = '1;
    burst_backlog.push_back(b);
    drain();

    // Typical calibration: extremes of each raw field, alerts on both sides
    program_set(0, 20'sd2500, 20'sd2000, 17'd40000);
    burst_backlog.push_back('{20'd0, 20'd0, 16'd0});
    burst_backlog.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    burst_backlog.push_back('{20'd519888, 20'd415148, 16'd30000});
    burst_backlog.push_back('{20'd519888, 20'd0, 16'd0});
    burst_backlog.push_back('{20'd519888, 20'hFFFFF, 16'hFFFF});
    burst_backlog.push_back('{20'd0, 20'd415148, 16'd30000});
    burst_backlog.push_back('{20'hFFFFF, 20'd415148, 16'd30000});
    burst_backlog.push_back('{20'd450000, 20'd300000, 16'd20000});
    burst_backlog.push_back('{20'd600000, 20'd500000, 16'd45000});
    drain();

    // All-ones calibration and extreme limits: wrap, saturation, divisor -1
    program_set(3, 20'sd524287, -20'sd524288, 17'd0);
    burst_backlog.push_back('{20'd0, 20'd0, 16'd0});
    burst_backlog.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    burst_backlog.push_back('{20'd519888, 20'd415148, 16'd30000});
    burst_backlog.push_back('{20'h55555, 20'hAAAAA, 16'h5555});
    drain();

    // Random phases: mostly realistic calibration, some fully random
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_set(0, 20'sd8500, -20'sd4000, 17'd102400);
        1: program_set(1, 20'($urandom_range(0, 4000)), 20'($urandom_range(0, 2000)),
                       17'($urandom_range(0, 102400)));
        2: program_set(2, 20'($urandom), 20'($urandom), 17'($urandom));
        3: program_set(1, 20'sd524287, -20'sd524288, 17'd102400);
        default: program_set(1, -20'sd524288, 20'sd524287, 17'h1FFFF);
      endcase
      for (int i = 0; i < 80; i++) burst_backlog.push_back(random_burst());
      drain();
    end

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
